// ===== sv/qts_pkg.sv =====
package qts_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_WAYPOINTS = 63;
    localparam int SHIFT_UP      = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHIFT_DN      = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int RF_DEPTH      = 32;
    localparam int RF_AW         = 5;
    localparam int PC_W          = 7;

    typedef logic signed [63:0] t_q;
    typedef logic [RF_AW-1:0]   t_raddr;
    typedef logic [PC_W-1:0]    t_pc;
    typedef logic [0:0]         t_cfg_idx;

    localparam t_q QMAX = 64'sh7fff_ffff_ffff_ffff;

    localparam t_cfg_idx CFG_STEP_TIME    = 1'b0;
    localparam t_cfg_idx CFG_TRACK_LENGTH = 1'b1;

    typedef struct packed {
        logic [31:0]        start_lon_pos;
        logic signed [31:0] start_lon_vel;
        logic signed [31:0] start_lon_acc;
        logic [31:0]        end_lon_pos;
        logic signed [31:0] end_lon_vel;
        logic signed [31:0] end_lon_acc;
        logic signed [31:0] start_lat_pos;
        logic signed [31:0] end_lat_pos;
        logic [31:0]        duration;
        logic [5:0]         waypoint_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        lon_pos;
        logic signed [31:0] lat_pos;
        logic               last;
        logic               bad_duration;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_LDI, OP_ADD, OP_SUB, OP_MUL, OP_MULK, OP_DIV, OP_WRAPR, OP_WRAPQ,
        OP_LATR, OP_LAT, OP_STEP, OP_EMITS, OP_EMIT
    } t_op;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_EMIT} t_state;

    typedef enum logic [0:0] {DIV_QUOT, DIV_WRAP} t_div_mode;

    typedef struct packed {
        t_op    op;
        t_raddr dst;
        t_raddr sa;
        t_raddr sb;
    } t_uinst;

    // register file map
    localparam t_raddr R_P0   = 5'd0;
    localparam t_raddr R_V0   = 5'd1;
    localparam t_raddr R_A0   = 5'd2;
    localparam t_raddr R_P1   = 5'd3;
    localparam t_raddr R_V1   = 5'd4;
    localparam t_raddr R_A1   = 5'd5;
    localparam t_raddr R_Q0   = 5'd6;
    localparam t_raddr R_Q1   = 5'd7;
    localparam t_raddr R_T    = 5'd8;
    localparam t_raddr R_RP0  = 5'd9;
    localparam t_raddr R_RQ0  = 5'd10;
    localparam t_raddr R_ZERO = 5'd11;
    localparam t_raddr R_C2   = 5'd12;
    localparam t_raddr R_T2   = 5'd13;
    localparam t_raddr R_T3   = 5'd14;
    localparam t_raddr R_T4   = 5'd15;
    localparam t_raddr R_T5   = 5'd16;
    localparam t_raddr R_X    = 5'd17;
    localparam t_raddr R_Y    = 5'd18;
    localparam t_raddr R_S0   = 5'd19;
    localparam t_raddr R_S1   = 5'd20;
    localparam t_raddr R_S2   = 5'd21;
    localparam t_raddr R_S1T  = 5'd22;
    localparam t_raddr R_S2T2 = 5'd23;
    localparam t_raddr R_S2H  = 5'd24;
    localparam t_raddr R_C3   = 5'd25;
    localparam t_raddr R_C4   = 5'd26;
    localparam t_raddr R_C5   = 5'd27;
    localparam t_raddr R_L3   = 5'd28;
    localparam t_raddr R_L4   = 5'd29;
    localparam t_raddr R_L5   = 5'd30;
    localparam t_raddr R_TS   = 5'd31;

    // constant operand codes for OP_MULK
    localparam t_raddr K_HALF = 5'd0;
    localparam t_raddr K_10   = 5'd1;
    localparam t_raddr K_4    = 5'd2;
    localparam t_raddr K_M15  = 5'd3;
    localparam t_raddr K_7    = 5'd4;
    localparam t_raddr K_6    = 5'd5;
    localparam t_raddr K_3    = 5'd6;

    localparam t_pc PC_LOOP = 7'd54;

    function automatic t_q kconst(input t_raddr k);
        t_q v;
        case (k)
            K_HALF:  v = t_q'(64'sd1 <<< (FRAC_BITS - 1));
            K_10:    v = t_q'(64'sd10 <<< FRAC_BITS);
            K_4:     v = t_q'(64'sd4 <<< FRAC_BITS);
            K_M15:   v = -t_q'(64'sd15 <<< FRAC_BITS);
            K_7:     v = t_q'(64'sd7 <<< FRAC_BITS);
            K_6:     v = t_q'(64'sd6 <<< FRAC_BITS);
            K_3:     v = t_q'(64'sd3 <<< FRAC_BITS);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] mag_of(input t_q v);
        return v[63] ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic t_q sat_mag(input logic neg, input logic [63:0] mag);
        t_q m;
        m = (mag > 64'(QMAX)) ? QMAX : t_q'(mag);
        return neg ? -m : m;
    endfunction

    function automatic t_q to_q(input t_q v);
        return (v <<< SHIFT_UP) >>> SHIFT_DN;
    endfunction

    function automatic t_q from_q(input t_q v);
        t_q f;
        t_q lim;
        f   = v >>> SHIFT_UP;
        lim = QMAX >>> SHIFT_DN;
        if (f > lim) return QMAX;
        if (f < -lim) return -QMAX;
        return f <<< SHIFT_DN;
    endfunction

    function automatic t_uinst ui(input t_op op, input t_raddr d, input t_raddr a,
                                  input t_raddr b);
        t_uinst u;
        u.op  = op;
        u.dst = d;
        u.sa  = a;
        u.sb  = b;
        return u;
    endfunction

    // microprogram: load, start point, coefficient solve, per-sample loop
    function automatic t_uinst ucode(input t_pc pc);
        t_uinst u;
        case (pc)
            7'd0:  u = ui(OP_LDI,   R_P0,   R_ZERO, R_ZERO);
            7'd1:  u = ui(OP_LDI,   R_V0,   R_ZERO, R_ZERO);
            7'd2:  u = ui(OP_LDI,   R_A0,   R_ZERO, R_ZERO);
            7'd3:  u = ui(OP_LDI,   R_P1,   R_ZERO, R_ZERO);
            7'd4:  u = ui(OP_LDI,   R_V1,   R_ZERO, R_ZERO);
            7'd5:  u = ui(OP_LDI,   R_A1,   R_ZERO, R_ZERO);
            7'd6:  u = ui(OP_LDI,   R_Q0,   R_ZERO, R_ZERO);
            7'd7:  u = ui(OP_LDI,   R_Q1,   R_ZERO, R_ZERO);
            7'd8:  u = ui(OP_LDI,   R_T,    R_ZERO, R_ZERO);
            7'd9:  u = ui(OP_LDI,   R_RP0,  R_ZERO, R_ZERO);
            7'd10: u = ui(OP_LDI,   R_RQ0,  R_ZERO, R_ZERO);
            7'd11: u = ui(OP_LDI,   R_ZERO, R_ZERO, R_ZERO);
            7'd12: u = ui(OP_WRAPR, R_ZERO, R_RP0,  R_ZERO);
            7'd13: u = ui(OP_LATR,  R_ZERO, R_RQ0,  R_ZERO);
            7'd14: u = ui(OP_EMITS, R_ZERO, R_ZERO, R_ZERO);
            7'd15: u = ui(OP_MULK,  R_C2,   R_A0,   K_HALF);
            7'd16: u = ui(OP_MUL,   R_T2,   R_T,    R_T);
            7'd17: u = ui(OP_MUL,   R_T3,   R_T2,   R_T);
            7'd18: u = ui(OP_MUL,   R_T4,   R_T3,   R_T);
            7'd19: u = ui(OP_MUL,   R_T5,   R_T4,   R_T);
            7'd20: u = ui(OP_MUL,   R_X,    R_V0,   R_T);
            7'd21: u = ui(OP_ADD,   R_Y,    R_P0,   R_X);
            7'd22: u = ui(OP_MUL,   R_X,    R_C2,   R_T2);
            7'd23: u = ui(OP_ADD,   R_Y,    R_Y,    R_X);
            7'd24: u = ui(OP_SUB,   R_S0,   R_P1,   R_Y);
            7'd25: u = ui(OP_MUL,   R_X,    R_A0,   R_T);
            7'd26: u = ui(OP_ADD,   R_Y,    R_V0,   R_X);
            7'd27: u = ui(OP_SUB,   R_S1,   R_V1,   R_Y);
            7'd28: u = ui(OP_SUB,   R_S2,   R_A1,   R_A0);
            7'd29: u = ui(OP_MUL,   R_S1T,  R_S1,   R_T);
            7'd30: u = ui(OP_MUL,   R_S2T2, R_S2,   R_T2);
            7'd31: u = ui(OP_MULK,  R_S2H,  R_S2T2, K_HALF);
            7'd32: u = ui(OP_MULK,  R_X,    R_S0,   K_10);
            7'd33: u = ui(OP_MULK,  R_Y,    R_S1T,  K_4);
            7'd34: u = ui(OP_SUB,   R_X,    R_X,    R_Y);
            7'd35: u = ui(OP_ADD,   R_X,    R_X,    R_S2H);
            7'd36: u = ui(OP_DIV,   R_C3,   R_X,    R_T3);
            7'd37: u = ui(OP_MULK,  R_X,    R_S0,   K_M15);
            7'd38: u = ui(OP_MULK,  R_Y,    R_S1T,  K_7);
            7'd39: u = ui(OP_ADD,   R_X,    R_X,    R_Y);
            7'd40: u = ui(OP_SUB,   R_X,    R_X,    R_S2T2);
            7'd41: u = ui(OP_DIV,   R_C4,   R_X,    R_T4);
            7'd42: u = ui(OP_MULK,  R_X,    R_S0,   K_6);
            7'd43: u = ui(OP_MULK,  R_Y,    R_S1T,  K_3);
            7'd44: u = ui(OP_SUB,   R_X,    R_X,    R_Y);
            7'd45: u = ui(OP_ADD,   R_X,    R_X,    R_S2H);
            7'd46: u = ui(OP_DIV,   R_C5,   R_X,    R_T5);
            7'd47: u = ui(OP_SUB,   R_S1,   R_Q1,   R_Q0);
            7'd48: u = ui(OP_MULK,  R_X,    R_S1,   K_10);
            7'd49: u = ui(OP_DIV,   R_L3,   R_X,    R_T3);
            7'd50: u = ui(OP_MULK,  R_X,    R_S1,   K_M15);
            7'd51: u = ui(OP_DIV,   R_L4,   R_X,    R_T4);
            7'd52: u = ui(OP_MULK,  R_X,    R_S1,   K_6);
            7'd53: u = ui(OP_DIV,   R_L5,   R_X,    R_T5);
            7'd54: u = ui(OP_STEP,  R_TS,   R_ZERO, R_ZERO);
            7'd55: u = ui(OP_MUL,   R_X,    R_C5,   R_TS);
            7'd56: u = ui(OP_ADD,   R_X,    R_X,    R_C4);
            7'd57: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd58: u = ui(OP_ADD,   R_X,    R_X,    R_C3);
            7'd59: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd60: u = ui(OP_ADD,   R_X,    R_X,    R_C2);
            7'd61: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd62: u = ui(OP_ADD,   R_X,    R_X,    R_V0);
            7'd63: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd64: u = ui(OP_ADD,   R_X,    R_X,    R_P0);
            7'd65: u = ui(OP_WRAPQ, R_ZERO, R_X,    R_ZERO);
            7'd66: u = ui(OP_MUL,   R_X,    R_L5,   R_TS);
            7'd67: u = ui(OP_ADD,   R_X,    R_X,    R_L4);
            7'd68: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd69: u = ui(OP_ADD,   R_X,    R_X,    R_L3);
            7'd70: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd71: u = ui(OP_ADD,   R_X,    R_X,    R_ZERO);
            7'd72: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd73: u = ui(OP_ADD,   R_X,    R_X,    R_ZERO);
            7'd74: u = ui(OP_MUL,   R_X,    R_X,    R_TS);
            7'd75: u = ui(OP_ADD,   R_X,    R_X,    R_Q0);
            7'd76: u = ui(OP_LAT,   R_ZERO, R_X,    R_ZERO);
            default: u = ui(OP_EMIT, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return u;
    endfunction

endpackage

// ===== sv/qts_stream_if.sv =====
interface qts_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/qts_rf.sv =====
module qts_rf (
    input  logic            i_clk,
    input  logic            i_we,
    input  qts_pkg::t_raddr i_wa,
    input  qts_pkg::t_q     i_wd,
    input  qts_pkg::t_raddr i_ra,
    input  qts_pkg::t_raddr i_rb,
    output qts_pkg::t_q     o_da,
    output qts_pkg::t_q     o_db
);
    import qts_pkg::*;

    t_q r_mem [RF_DEPTH];
    t_q r_da;
    t_q r_db;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_da <= r_mem[i_ra];
        r_db <= r_mem[i_rb];
    end

    assign o_da = r_da;
    assign o_db = r_db;
endmodule

// ===== sv/qts_mul.sv =====
module qts_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  qts_pkg::t_q i_a,
    input  qts_pkg::t_q i_b,
    output logic        o_done,
    output qts_pkg::t_q o_p
);
    import qts_pkg::*;

    localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [63:0]  r_part;
    logic [1:0]   r_psel;
    logic [2:0]   r_phase;
    logic         r_busy;
    logic         r_fin;
    logic [31:0]  w_xs;
    logic [31:0]  w_ys;
    logic [127:0] w_part_sh;

    // partial order: x0*y0, x0*y1, x1*y0, x1*y1
    always_comb begin
        w_xs = r_phase[1] ? r_x[63:32] : r_x[31:0];
        w_ys = r_phase[0] ? r_y[63:32] : r_y[31:0];
        case (r_psel)
            2'd0:    w_part_sh = {64'd0, r_part};
            2'd3:    w_part_sh = {r_part, 64'd0};
            default: w_part_sh = {32'd0, r_part, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_phase <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (r_busy) begin
                r_phase <= r_phase + 3'd1;
                if (r_phase == 3'd4) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= mag_of(i_a);
            r_y   <= mag_of(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= RND;
        end else if (r_busy) begin
            if (r_phase != 3'd4) begin
                r_part <= 64'(w_xs) * 64'(w_ys);
                r_psel <= r_phase[1:0];
            end
            if (r_phase != 3'd0) begin
                r_acc <= r_acc + w_part_sh;
            end
        end
    end

    assign o_done = r_fin;
    assign o_p = sat_mag(r_neg, (|r_acc[127:64+FRAC_BITS]) ? 64'hffff_ffff_ffff_ffff
                                                          : r_acc[64+FRAC_BITS-1:FRAC_BITS]);
endmodule

// ===== sv/qts_div.sv =====
module qts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  qts_pkg::t_div_mode i_mode,
    input  qts_pkg::t_q        i_a,
    input  qts_pkg::t_q        i_b,
    output logic               o_done,
    output qts_pkg::t_q        o_r
);
    import qts_pkg::*;

    logic [127:0] r_num;
    logic [63:0]  r_d;
    logic [63:0]  r_rem;
    logic [63:0]  r_quo;
    logic         r_ovf;
    t_div_mode    r_mode;
    logic         r_neg;
    logic         r_aneg;
    logic         r_xz;
    logic         r_dz;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic         r_fin;
    logic [63:0]  w_x;
    logic [63:0]  w_d;
    logic [64:0]  w_sh;
    logic [64:0]  w_diff;
    logic         w_ge;

    assign w_x    = mag_of(i_a);
    assign w_d    = (i_mode == DIV_WRAP) ? 64'(i_b) : mag_of(i_b);
    assign w_sh   = {r_rem, r_num[127]};
    assign w_ge   = w_sh >= {1'b0, r_d};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_mode == DIV_WRAP) ? 8'd64 : 8'd128;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // restoring long division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_d    <= w_d;
            r_rem  <= '0;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
            r_neg  <= i_a[63] ^ i_b[63];
            r_aneg <= i_a[63];
            r_xz   <= (w_x == 64'd0);
            r_dz   <= (w_d == 64'd0);
            if (i_mode == DIV_WRAP) begin
                r_num <= {w_x, 64'd0};
            end else begin
                r_num <= ({64'd0, w_x} << FRAC_BITS) + {65'd0, w_d[63:1]};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[63:0] : w_sh[63:0];
            r_quo <= {r_quo[62:0], w_ge};
            r_ovf <= r_ovf | r_quo[63];
            r_num <= r_num << 1;
        end
    end

    always_comb begin
        if (r_mode == DIV_WRAP) begin
            o_r = (r_aneg && r_rem != 64'd0) ? t_q'(r_d - r_rem) : t_q'(r_rem);
        end else if (r_xz) begin
            o_r = '0;
        end else if (r_dz) begin
            o_r = sat_mag(r_aneg, 64'hffff_ffff_ffff_ffff);
        end else begin
            o_r = sat_mag(r_neg, r_ovf ? 64'hffff_ffff_ffff_ffff : r_quo);
        end
    end

    assign o_done = r_fin;
endmodule

// ===== sv/quintic_trajectory_sampler_top.sv =====
// channel  dir  payload                                      transfer when
// i_in     in   start/end lon pos, vel, acc; lat pos; T; n    i_in.valid & i_in.ready
// o_out    out  lon_pos, lat_pos, last, bad_duration          o_out.valid & o_out.ready
// cfg      in   i_cfg_idx, i_cfg_data                         i_cfg_we
//
// one maneuver at a time; i_in.ready is high only while idle
// start point leaves after the loads, plus a remainder on the divider with track wrap
// the solve then runs six divides on the shared divider, when waypoints follow
// each waypoint runs ten products on the shared multiplier,
// plus a remainder on the divider when track_length is nonzero
// reset is synchronous active low; a stalled output holds the sequencer
module quintic_trajectory_sampler_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  qts_pkg::t_cfg_idx i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    qts_stream_if.sink        i_in,
    qts_stream_if.source      o_out
);
    import qts_pkg::*;

    // control state
    t_state      r_state;
    t_state      n_state;
    t_pc         r_pc;
    logic [15:0] r_step;
    logic [31:0] r_track;
    logic [5:0]  r_left;
    logic [31:0] r_time;

    // captured maneuver and output register
    t_in_item    r_in;
    logic [5:0]  r_count;
    logic [31:0] r_lon;
    logic [31:0] r_lat;
    logic        r_last;
    logic        r_bad;

    // datapath wires
    t_uinst      w_u;
    t_q          w_da;
    t_q          w_db;
    t_q          w_sum;
    t_q          w_mul_b;
    t_q          w_mul_p;
    t_q          w_div_a;
    t_q          w_div_b;
    t_q          w_div_r;
    t_q          w_lon_q;
    logic        w_mul_done;
    logic        w_div_done;
    logic        w_mul_start;
    logic        w_div_start;
    t_div_mode   w_div_mode;
    logic        w_rf_we;
    t_q          w_rf_wd;
    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_is_wrap;
    logic        w_has_track;
    logic [31:0] w_time_nx;
    logic [5:0]  w_cnt_in;

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'(QMAX)) return QMAX;
        if (s < -65'(QMAX)) return -QMAX;
        return s[63:0];
    endfunction

    function automatic logic [31:0] sat32(input t_q v);
        if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_q sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // input field for a load, rescaled to internal format except the raw start-point copies
    function automatic t_q ld_value(input t_raddr d, input t_in_item it);
        t_q v;
        case (d)
            R_P0:    v = to_q({32'd0, it.start_lon_pos});
            R_V0:    v = to_q(sext32(it.start_lon_vel));
            R_A0:    v = to_q(sext32(it.start_lon_acc));
            R_P1:    v = to_q({32'd0, it.end_lon_pos});
            R_V1:    v = to_q(sext32(it.end_lon_vel));
            R_A1:    v = to_q(sext32(it.end_lon_acc));
            R_Q0:    v = to_q(sext32(it.start_lat_pos));
            R_Q1:    v = to_q(sext32(it.end_lat_pos));
            R_T:     v = to_q({32'd0, it.duration});
            R_RP0:   v = {32'd0, it.start_lon_pos};
            R_RQ0:   v = sext32(it.start_lat_pos);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_u         = ucode(r_pc);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_xfer  = o_out.valid && o_out.ready;
    assign w_is_wrap   = (w_u.op == OP_WRAPR) || (w_u.op == OP_WRAPQ);
    assign w_has_track = (r_track != 32'd0);
    assign w_time_nx   = r_time + {16'd0, r_step};
    assign w_sum       = sat_add(w_da, (w_u.op == OP_SUB) ? -w_db : w_db);
    assign w_lon_q     = (w_u.op == OP_WRAPQ) ? from_q(w_da) : w_da;
    assign w_cnt_in    = (i_in.data.waypoint_count > 6'(MAX_WAYPOINTS)) ? 6'(MAX_WAYPOINTS)
                                                                       : i_in.data.waypoint_count;

    // operand register file, read addresses straight from the microword
    qts_rf u_rf (
        .i_clk (i_clk),
        .i_we  (w_rf_we),
        .i_wa  (w_u.dst),
        .i_wd  (w_rf_wd),
        .i_ra  (w_u.sa),
        .i_rb  (w_u.sb),
        .o_da  (w_da),
        .o_db  (w_db)
    );

    assign w_mul_b = (w_u.op == OP_MULK) ? kconst(w_u.sb) : w_db;

    qts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_da),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    assign w_div_mode = w_is_wrap ? DIV_WRAP : DIV_QUOT;
    assign w_div_a    = w_is_wrap ? w_lon_q : w_da;
    assign w_div_b    = w_is_wrap ? t_q'({32'd0, r_track}) : w_db;

    // shared divider: quotients for the solve, remainder for the track wrap
    qts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mode  (w_div_mode),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .o_done  (w_div_done),
        .o_r     (w_div_r)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_FETCH;
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                unique case (w_u.op) inside
                    OP_MUL, OP_MULK, OP_DIV: n_state = S_WAIT;
                    OP_WRAPR, OP_WRAPQ:      n_state = w_has_track ? S_WAIT : S_FETCH;
                    OP_EMITS, OP_EMIT:       n_state = S_EMIT;
                    default:                 n_state = S_FETCH;
                endcase
            end
            S_WAIT:  if (w_mul_done || w_div_done) n_state = S_FETCH;
            S_EMIT:  if (o_out.ready) n_state = r_last ? S_IDLE : S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_rf_we     = 1'b0;
        w_rf_wd     = w_sum;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                unique case (w_u.op) inside
                    OP_LDI: begin
                        w_rf_we = 1'b1;
                        w_rf_wd = ld_value(w_u.dst, r_in);
                    end
                    OP_ADD, OP_SUB: w_rf_we = 1'b1;
                    OP_STEP: begin
                        w_rf_we = 1'b1;
                        w_rf_wd = to_q({32'd0, w_time_nx});
                    end
                    OP_MUL, OP_MULK:    w_mul_start = 1'b1;
                    OP_DIV:             w_div_start = 1'b1;
                    OP_WRAPR, OP_WRAPQ: w_div_start = w_has_track;
                    default: ;
                endcase
            end
            S_WAIT: begin
                if (w_u.op == OP_MUL || w_u.op == OP_MULK) begin
                    w_rf_we = w_mul_done;
                    w_rf_wd = w_mul_p;
                end else if (w_u.op == OP_DIV) begin
                    w_rf_we = w_div_done;
                    w_rf_wd = w_div_r;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = (r_state == S_EMIT);
    assign o_out.data.lon_pos      = r_lon;
    assign o_out.data.lat_pos      = r_lat;
    assign o_out.data.last         = r_last;
    assign o_out.data.bad_duration = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_step  <= 16'd1311;
            r_track <= '0;
            r_left  <= '0;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEP_TIME:    r_step  <= i_cfg_data[15:0];
                    CFG_TRACK_LENGTH: r_track <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                r_pc   <= '0;
                r_time <= '0;
                r_left <= (i_in.data.duration == 32'd0) ? 6'd0 : w_cnt_in;
            end else begin
                if ((r_state == S_EXEC || r_state == S_WAIT) && n_state == S_FETCH) begin
                    r_pc <= r_pc + 1'b1;
                end
                if (r_state == S_EMIT && w_out_xfer && !r_last) begin
                    r_pc <= (w_u.op == OP_EMIT) ? PC_LOOP : r_pc + 1'b1;
                end
                if (r_state == S_EXEC && w_u.op == OP_STEP) begin
                    r_time <= w_time_nx;
                end
                if (r_state == S_EXEC && w_u.op == OP_EMIT) begin
                    r_left <= r_left - 6'd1;
                end
            end
        end
    end

    // maneuver capture and result fields
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in    <= i_in.data;
            r_count <= (i_in.data.duration == 32'd0) ? 6'd0 : w_cnt_in;
        end
        if (r_state == S_EXEC) begin
            case (w_u.op) inside
                OP_WRAPR, OP_WRAPQ: if (!w_has_track) r_lon <= w_lon_q[31:0];
                OP_LATR:            r_lat <= w_da[31:0];
                OP_LAT:             r_lat <= sat32(from_q(w_da));
                OP_EMITS: begin
                    r_last <= (r_count == 6'd0);
                    r_bad  <= (r_in.duration == 32'd0);
                end
                OP_EMIT: begin
                    r_last <= (r_left == 6'd1);
                    r_bad  <= 1'b0;
                end
                default: ;
            endcase
        end
        if (r_state == S_WAIT && w_is_wrap && w_div_done) begin
            r_lon <= w_div_r[31:0];
        end
    end

    // no new maneuver is taken while a result waits
    a_ready_vs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    // the final transfer returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out.data.last) |=> i_in.ready)
        else $error("block not idle after last transfer");

    // a flagged duration only ever shows on a final start point
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.data.bad_duration || o_out.data.last))
        else $error("bad_duration on a non-final result");

    // multiplier and divider never run at once
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("two arithmetic units finished together");
endmodule

// ===== bench/testbench.sv =====
module testbench;
    import qts_pkg::*;

    // clock, reset and configuration port
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_data;

    // maneuver in, waypoints out
    qts_stream_if #(.t_payload(t_in_item))  stim_ch();
    qts_stream_if #(.t_payload(t_out_item)) wp_ch();

    quintic_trajectory_sampler_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (stim_ch.sink),
        .o_out      (wp_ch.source)
    );

    // shadow of the block's registers and solver state
    logic [15:0] step_sh;
    logic [31:0] track_sh;
    t_q          lon_c[6];
    t_q          lat_c[6];

    t_out_item   waypoints_due[$];
    int          mismatches;
    int          unexpected;
    bit          calm;           // phase without idling on either side
    int          maneuvers_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // fixed-point helpers: saturating sum, rounded product and quotient
    // ---------------------------------------------------------------
    function automatic t_q fx_sum(input t_q a, input t_q b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(QMAX)) return QMAX;
        if (s < -65'(QMAX)) return -QMAX;
        return t_q'(s);
    endfunction

    function automatic t_q fx_mul(input t_q a, input t_q b);
        logic [63:0]  ma, mb, mag;
        logic [127:0] p;
        ma  = a[63] ? -a : a;
        mb  = b[63] ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag = (p > {64'd0, 64'(QMAX)}) ? 64'(QMAX) : p[63:0];
        return (a[63] ^ b[63]) ? -t_q'(mag) : t_q'(mag);
    endfunction

    function automatic t_q fx_div(input t_q a, input t_q b);
        logic [63:0]  ma, mb, mag;
        logic [127:0] n, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        if (ma == 0) return '0;
        // zero divisor saturates with the numerator's sign
        if (mb == 0) return a[63] ? -QMAX : QMAX;
        n   = ({64'd0, ma} << FRAC_BITS) + {64'd0, mb >> 1};
        q   = n / {64'd0, mb};
        mag = (q > {64'd0, 64'(QMAX)}) ? 64'(QMAX) : q[63:0];
        return (a[63] ^ b[63]) ? -t_q'(mag) : t_q'(mag);
    endfunction

    function automatic t_q fx_k(input t_q a, input int k);
        return fx_mul(a, t_q'(k) * (t_q'(1) <<< FRAC_BITS));
    endfunction

    function automatic t_q q_in(input t_q v);
        return (v <<< SHIFT_UP) >>> SHIFT_DN;
    endfunction

    function automatic t_q q_out(input t_q v);
        t_q f;
        f = v >>> SHIFT_UP;
        if (f > (QMAX >>> SHIFT_DN)) return QMAX;
        if (f < -(QMAX >>> SHIFT_DN)) return -QMAX;
        return f <<< SHIFT_DN;
    endfunction

    // non-negative remainder along the track, or plain low word when no wrap
    function automatic logic [31:0] wrap_track(input t_q v);
        longint r;
        if (track_sh != 0) begin
            r = v % longint'({32'd0, track_sh});
            if (r < 0) r = r + longint'({32'd0, track_sh});
            return r[31:0];
        end
        return v[31:0];
    endfunction

    // closed-form jerk-minimizing coefficients for one axis
    task automatic solve_quintic(output t_q c[6], input t_q p0, input t_q v0,
                                 input t_q a0, input t_q p1, input t_q v1,
                                 input t_q a1, input t_q t, input bit ok);
        t_q half, t2, t3, t4, t5, s0, s1, s2, s1t, s2t2, s2h;
        half = t_q'(1) <<< (FRAC_BITS - 1);
        c[0] = p0;
        c[1] = v0;
        c[2] = fx_mul(a0, half);
        c[3] = '0;
        c[4] = '0;
        c[5] = '0;
        if (ok) begin
            t2   = fx_mul(t, t);
            t3   = fx_mul(t2, t);
            t4   = fx_mul(t3, t);
            t5   = fx_mul(t4, t);
            s0   = fx_sum(p1, -fx_sum(fx_sum(p0, fx_mul(v0, t)), fx_mul(c[2], t2)));
            s1   = fx_sum(v1, -fx_sum(v0, fx_mul(a0, t)));
            s2   = fx_sum(a1, -a0);
            s1t  = fx_mul(s1, t);
            s2t2 = fx_mul(s2, t2);
            s2h  = fx_mul(s2t2, half);
            c[3] = fx_div(fx_sum(fx_sum(fx_k(s0, 10), -fx_k(s1t, 4)), s2h), t3);
            c[4] = fx_div(fx_sum(fx_sum(fx_k(s0, -15), fx_k(s1t, 7)), -s2t2), t4);
            c[5] = fx_div(fx_sum(fx_sum(fx_k(s0, 6), -fx_k(s1t, 3)), s2h), t5);
        end
    endtask

    function automatic t_q eval_poly(input t_q c[6], input t_q t);
        t_q p;
        p = c[5];
        for (int i = 4; i >= 0; i--) p = fx_sum(fx_mul(p, t), c[i]);
        return p;
    endfunction

    // queue every waypoint that one maneuver must produce
    task automatic plan_waypoints(input t_in_item m, input bit typed_head,
                                  input t_out_item head);
        t_q          dur_q;
        bit          ok;
        int          n;
        logic [31:0] ts;
        t_q          s, d;
        t_out_item   w;
        ok    = (m.duration != 0);
        n     = ok ? m.waypoint_count : 0;
        if (n > MAX_WAYPOINTS) n = MAX_WAYPOINTS;
        dur_q = q_in(t_q'({32'd0, m.duration}));
        solve_quintic(lon_c, q_in(t_q'({32'd0, m.start_lon_pos})), q_in(t_q'(m.start_lon_vel)),
                      q_in(t_q'(m.start_lon_acc)), q_in(t_q'({32'd0, m.end_lon_pos})),
                      q_in(t_q'(m.end_lon_vel)), q_in(t_q'(m.end_lon_acc)), dur_q, ok);
        solve_quintic(lat_c, q_in(t_q'(m.start_lat_pos)), '0, '0,
                      q_in(t_q'(m.end_lat_pos)), '0, '0, dur_q, ok);
        // start point repeats the inputs
        w.lon_pos      = wrap_track(t_q'({32'd0, m.start_lon_pos}));
        w.lat_pos      = m.start_lat_pos;
        w.last         = (n == 0);
        w.bad_duration = !ok;
        waypoints_due = {waypoints_due, (typed_head ? head : w)};
        ts = '0;
        for (int k = 1; k <= n; k++) begin
            ts = ts + {16'd0, step_sh};
            s  = q_out(eval_poly(lon_c, q_in(t_q'({32'd0, ts}))));
            d  = q_out(eval_poly(lat_c, q_in(t_q'({32'd0, ts}))));
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            if (d < -64'sd2147483648) d = -64'sd2147483648;
            w.lon_pos      = wrap_track(s);
            w.lat_pos      = d[31:0];
            w.last         = (k == n);
            w.bad_duration = 1'b0;
            waypoints_due = {waypoints_due, w};
        end
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    function automatic int draw_wait();
        return calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_STEP_TIME) step_sh = val[15:0];
        else track_sh = val;
    endtask

    // hand one maneuver over; valid stays high when the next gap is zero
    task automatic send_maneuver(input t_in_item m, input bit typed_head,
                                 input t_out_item head);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            stim_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        stim_ch.valid <= 1'b1;
        stim_ch.data  <= m;
        do @(posedge i_clk); while (!(stim_ch.valid && stim_ch.ready));
        plan_waypoints(m, typed_head, head);
        maneuvers_sent++;
    endtask

    task automatic drain();
        stim_ch.valid <= 1'b0;
        while (waypoints_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // well-formed maneuvers mostly, raw noise the rest
    function automatic t_in_item random_maneuver();
        t_in_item m;
        m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 6'($urandom)};
        if ($urandom_range(0, 9) < 7) begin
            m.start_lon_vel = 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
            m.start_lon_acc = 32'($signed($urandom_range(0, 10 << 16)) - (5 << 16));
            m.end_lon_pos   = m.start_lon_pos + $urandom_range(0, 200 << 16);
            m.end_lon_vel   = 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
            m.end_lon_acc   = 32'($signed($urandom_range(0, 10 << 16)) - (5 << 16));
            m.start_lat_pos = 32'($signed($urandom_range(0, 10 << 16)) - (5 << 16));
            m.end_lat_pos   = 32'($signed($urandom_range(0, 10 << 16)) - (5 << 16));
            m.duration      = $urandom_range(1 << 15, 10 << 16);
        end else if ($urandom_range(0, 7) == 0) begin
            m.duration = '0;
        end
        // long trajectories are rare
        m.waypoint_count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, 8));
        return m;
    endfunction

    // ---------------------------------------------------------------
    // waypoint receiver and checker
    // ---------------------------------------------------------------
    initial begin
        t_out_item got, want;
        int        stall;
        wp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                wp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(wp_ch.valid && wp_ch.ready));
            got = wp_ch.data;
            if (waypoints_due.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected waypoint lon=%h lat=%h last=%b bad=%b",
                             got.lon_pos, got.lat_pos, got.last, got.bad_duration);
            end else begin
                want = waypoints_due.pop_front();
                if (got.lon_pos !== want.lon_pos || got.lat_pos !== want.lat_pos ||
                    got.last !== want.last || got.bad_duration !== want.bad_duration) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10) begin
                        $display("waypoint mismatch: exp lon=%h lat=%h last=%b bad=%b",
                                 want.lon_pos, want.lat_pos, want.last, want.bad_duration);
                        $display("                   got lon=%h lat=%h last=%b bad=%b",
                                 got.lon_pos, got.lat_pos, got.last, got.bad_duration);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // directed table, then random phases under several settings
    // ---------------------------------------------------------------
    typedef struct {
        t_in_item  m;
        bit        typed;
        t_out_item head;
    } t_row;

    function automatic t_row row(input logic [31:0] p0, input logic [31:0] v0,
                                 input logic [31:0] a0, input logic [31:0] p1,
                                 input logic [31:0] v1, input logic [31:0] a1,
                                 input logic [31:0] q0, input logic [31:0] q1,
                                 input logic [31:0] dur, input logic [5:0] n,
                                 input bit typed, input bit last, input bit bad);
        t_row r;
        r.m             = {p0, v0, a0, p1, v1, a1, q0, q1, dur, n};
        r.typed         = typed;
        r.head          = {p0, q0, last, bad};
        return r;
    endfunction

    initial begin
        t_row rows[$];
        logic [31:0] steps[6]  = '{32'd65535, 32'd1, 32'hfff0_0001, 32'd6554,
                                   32'd0, 32'd1311};
        logic [31:0] tracks[6] = '{32'd0, 32'hffff_ffff, 32'd100 << 16, 32'd1,
                                   32'd0, 32'd0};
        mismatches     = 0;
        unexpected     = 0;
        maneuvers_sent = 0;
        calm           = 1'b0;
        step_sh        = 16'd1311;
        track_sh       = '0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_STEP_TIME;
        i_cfg_data     <= '0;
        stim_ch.valid  <= 1'b0;
        stim_ch.data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        // zero duration: start point only, flagged
        rows = {rows, row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1)};
        rows = {rows, row(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          0, 63, 1, 1, 1)};
        // zero count: start point only, not flagged
        rows = {rows, row(32'h0001_0000, 32'h0002_0000, 0, 32'h0010_0000, 0, 0,
                          32'h7fff_ffff, 0, 32'h0001_0000, 0, 1, 1, 0)};
        // plain maneuvers
        rows = {rows, row(10 << 16, 5 << 16, 0, 30 << 16, 5 << 16, 0,
                          0, 3 << 16, 2 << 16, 5, 0, 0, 0)};
        rows = {rows, row(0, 0, 1 << 16, 100 << 16, 20 << 16, 0,
                          32'hfffe_0000, 2 << 16, 5 << 16, 63, 0, 0, 0)};
        // longest duration
        rows = {rows, row(1 << 16, 1 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16,
                          32'hffff_ffff, 3, 0, 0, 0)};
        // tiny duration: powers of T round to zero
        rows = {rows, row(5 << 16, 1 << 16, 0, 6 << 16, 0, 0, 1 << 16, 2 << 16,
                          1, 2, 0, 0, 0)};
        rows = {rows, row(0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 0, 0, 0)};
        // all fields at their largest / most negative
        rows = {rows, row(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'hffff_ffff, 63, 0, 0, 0)};
        rows = {rows, row(0, 32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_8000,
                          4, 0, 0, 0)};
        // lateral swing beyond the 32-bit range
        rows = {rows, row(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
                          32'h0000_4000, 6, 0, 0, 0)};
        // backing up below zero along the track
        rows = {rows, row(1 << 16, 32'hfff6_0000, 0, 0, 0, 0, 0, 0,
                          2 << 16, 8, 0, 0, 0)};

        foreach (rows[i]) send_maneuver(rows[i].m, rows[i].typed, rows[i].head);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_STEP_TIME, (steps[ph][15:0] == 0) ? 32'($urandom_range(1, 65535))
                                                            : steps[ph]);
            write_reg(CFG_TRACK_LENGTH, (ph == 4) ? $urandom : tracks[ph]);
            calm = (ph == 2);
            for (int k = 0; k < 76; k++) begin
                send_maneuver(random_maneuver(), 1'b0, '0);
                // hold off once until the block has caught up
                if (ph == 1 && k == 30) begin
                    stim_ch.valid <= 1'b0;
                    while (waypoints_due.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && unexpected == 0 && waypoints_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // runaway guard
    initial begin
        #500_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
